### hdl/weekday_alarm_matcher_with_buzz_pattern_defines.svh
// Assertion macros for the weekday alarm matcher.
// Used by the top level only; no other dependencies.
`ifndef WEEKDAY_ALARM_MATCHER_WITH_BUZZ_PATTERN_DEFINES_SVH
`define WEEKDAY_ALARM_MATCHER_WITH_BUZZ_PATTERN_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WAM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/wam_pkg.sv
// Shared types and constants of the weekday alarm matcher.
// No dependencies; imported by the slot cell, the pattern engine and the top level.
`default_nettype none

package wam_pkg;

   localparam int ALARM_SLOTS = 8;

   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int DAYS_W   = 7;
   localparam int MS_W     = 16;
   localparam int REP_W    = 4;

   // item action codes
   localparam logic [2:0] ACT_CHECK = 3'd0;
   localparam logic [2:0] ACT_TICK  = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_STOP  = 3'd3;
   localparam logic [2:0] ACT_FIND  = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_ALARM_ON  = 3'd0;
   localparam logic [2:0] CSR_ALARM_OFF = 3'd1;
   localparam logic [2:0] CSR_ALARM_REP = 3'd2;
   localparam logic [2:0] CSR_FIND_ON   = 3'd3;
   localparam logic [2:0] CSR_FIND_OFF  = 3'd4;
   localparam logic [2:0] CSR_FIND_REP  = 3'd5;

   // one alarm slot as held by a cell
   typedef struct packed {
      logic                enable;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [DAYS_W-1:0]   days;
   } slot_type;

   // search token walking down the row of cells
   typedef struct packed {
      logic                valid;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [DAYS_W-1:0]   day_mask;
   } probe_type;

   typedef struct packed {
      logic hit;
      logic save;
   } hit_type;

   typedef struct packed {
      logic [MS_W-1:0]  alarm_on_ms;
      logic [MS_W-1:0]  alarm_off_ms;
      logic [REP_W-1:0] alarm_repeats;
      logic [MS_W-1:0]  find_on_ms;
      logic [MS_W-1:0]  find_off_ms;
      logic [REP_W-1:0] find_repeats;
   } cfg_type;

   typedef struct packed {
      logic alarm;
      logic tick;
      logic stop;
      logic find;
   } eng_cmd_type;

   typedef struct packed {
      logic on_pulse;
      logic off_pulse;
      logic ended;
      logic alarm_active;
      logic find_active;
   } eng_rsp_type;

   typedef struct packed {
      logic alarm_running;
      logic find_running;
   } eng_status_type;

endpackage

`default_nettype wire

### hdl/wam_slot_cell.sv
// One alarm slot cell of the search row: holds a slot and passes the search token on.
// Depends on wam_pkg.
`default_nettype none

module wam_slot_cell
   import wam_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   input  wire       wr_en,
   input  slot_type  wr_slot,
   input  probe_type probe_in,
   output probe_type probe_out,
   output hit_type   hit_out
);

   slot_type  slot_ff, slot_in;
   probe_type probe_ff, probe_in_next;
   hit_type   hit_ff, hit_in;
   logic      time_match;
   logic      one_shot;

   always_comb begin
      time_match = probe_in.valid && slot_ff.enable &&
                   (slot_ff.hour == probe_in.hour) && (slot_ff.minute == probe_in.minute);
      one_shot   = (slot_ff.days == '0);

      hit_in.hit  = time_match && (one_shot || ((slot_ff.days & probe_in.day_mask) != '0));
      hit_in.save = time_match && one_shot;

      // pass the token on only if this slot did not take it
      probe_in_next       = probe_in;
      probe_in_next.valid = probe_in.valid && !hit_in.hit;

      slot_in = slot_ff;
      if (wr_en) begin
         slot_in = wr_slot;
      end else if (hit_in.save) begin
         slot_in.enable = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         probe_ff <= '0;
         hit_ff   <= '0;
      end else begin
         slot_ff  <= slot_in;
         probe_ff <= probe_in_next;
         hit_ff   <= hit_in;
      end
   end

   assign probe_out = probe_ff;
   assign hit_out   = hit_ff;

endmodule

`default_nettype wire

### hdl/wam_engine.sv
// Shared vibration pattern engine: on phase, off phase and burst count per pattern.
// Depends on wam_pkg.
`default_nettype none

module wam_engine
   import wam_pkg::*;
(
   input  wire            clock,
   input  wire            reset,
   input  cfg_type        cfg,
   input  eng_cmd_type    cmd,
   output eng_rsp_type    rsp,
   output eng_status_type status
);

   logic [MS_W-1:0]  timer_ff, timer_in;
   logic [REP_W-1:0] bursts_ff, bursts_in;
   logic             motor_ff, motor_in;
   logic             alarm_ff, alarm_in;
   logic             find_ff, find_in;
   logic [MS_W-1:0]  timer_dec;
   logic [MS_W-1:0]  on_len;
   logic [MS_W-1:0]  off_len;

   function automatic logic [MS_W-1:0] at_least_one_ms(input logic [MS_W-1:0] v);
      return (v == '0) ? MS_W'(1) : v;
   endfunction

   function automatic logic [REP_W-1:0] at_least_one_rep(input logic [REP_W-1:0] v);
      return (v == '0) ? REP_W'(1) : v;
   endfunction

   always_comb begin
      timer_in  = timer_ff;
      bursts_in = bursts_ff;
      motor_in  = motor_ff;
      alarm_in  = alarm_ff;
      find_in   = find_ff;
      rsp       = '0;

      timer_dec = (timer_ff != '0) ? (timer_ff - MS_W'(1)) : '0;
      on_len    = alarm_ff ? cfg.alarm_on_ms  : cfg.find_on_ms;
      off_len   = alarm_ff ? cfg.alarm_off_ms : cfg.find_off_ms;

      if (cmd.alarm) begin
         // alarm takes the engine over, ending a find pattern
         rsp.ended    = find_ff;
         find_in      = 1'b0;
         alarm_in     = 1'b1;
         timer_in     = at_least_one_ms(cfg.alarm_on_ms);
         bursts_in    = at_least_one_rep(cfg.alarm_repeats);
         motor_in     = 1'b1;
         rsp.on_pulse = 1'b1;
      end else if (cmd.tick) begin
         if (alarm_ff || find_ff) begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               if (motor_ff) begin
                  motor_in      = 1'b0;
                  rsp.off_pulse = 1'b1;
                  if (bursts_ff > REP_W'(1)) begin
                     bursts_in = bursts_ff - REP_W'(1);
                     timer_in  = at_least_one_ms(off_len);
                  end else begin
                     bursts_in = '0;
                     alarm_in  = 1'b0;
                     find_in   = 1'b0;
                     rsp.ended = 1'b1;
                  end
               end else begin
                  motor_in     = 1'b1;
                  rsp.on_pulse = 1'b1;
                  timer_in     = at_least_one_ms(on_len);
               end
            end
         end
      end else if (cmd.stop) begin
         if (alarm_ff) begin
            alarm_in      = 1'b0;
            motor_in      = 1'b0;
            bursts_in     = '0;
            timer_in      = '0;
            rsp.off_pulse = 1'b1;
            rsp.ended     = 1'b1;
         end
      end else if (cmd.find) begin
         if (!find_ff && !alarm_ff) begin
            find_in      = 1'b1;
            timer_in     = at_least_one_ms(cfg.find_on_ms);
            bursts_in    = at_least_one_rep(cfg.find_repeats);
            motor_in     = 1'b1;
            rsp.on_pulse = 1'b1;
         end
      end

      rsp.alarm_active = alarm_in;
      rsp.find_active  = find_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff  <= '0;
         bursts_ff <= '0;
         motor_ff  <= 1'b0;
         alarm_ff  <= 1'b0;
         find_ff   <= 1'b0;
      end else begin
         timer_ff  <= timer_in;
         bursts_ff <= bursts_in;
         motor_ff  <= motor_in;
         alarm_ff  <= alarm_in;
         find_ff   <= find_in;
      end
   end

   assign status.alarm_running = alarm_ff;
   assign status.find_running  = find_ff;

endmodule

`default_nettype wire

### hdl/weekday_alarm_matcher_with_buzz_pattern.sv
// Weekday alarm matcher with buzz pattern: top level, row of slot cells plus pattern engine.
// Tick, stop, find, slot write and unknown items: result valid in the cycle after accept.
// Minute check: the token walks one slot cell per cycle from the launch register; the walk
// ends on a hit or when the token leaves the last cell; no item is taken during the walk.
// Other items can be taken every cycle while the result register is not stalled.
// Sync reset clears slots, engine and state, loads config defaults; payload is not reset.
`default_nettype none
`include "weekday_alarm_matcher_with_buzz_pattern_defines.svh"

module weekday_alarm_matcher_with_buzz_pattern
   import wam_pkg::*;
(
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_action,
   input  wire  [4:0]  req_now_hour,
   input  wire  [5:0]  req_now_minute,
   input  wire  [2:0]  req_now_weekday,
   input  wire  [2:0]  req_slot_index,
   input  wire         req_slot_enable,
   input  wire  [4:0]  req_slot_hour,
   input  wire  [5:0]  req_slot_minute,
   input  wire  [6:0]  req_slot_days,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_buzz_on_pulse,
   output logic        rsp_buzz_off_pulse,
   output logic        rsp_alarm_active,
   output logic        rsp_find_active,
   output logic        rsp_alarm_fired,
   output logic [2:0]  rsp_fired_slot,
   output logic        rsp_save_needed,
   output logic        rsp_pattern_ended,

   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wr_data
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type      state_ff;
   cfg_type        cfg_ff;
   probe_type      launch_ff;
   probe_type      launch_in;
   probe_type      chain [ALARM_SLOTS+1];
   hit_type        cell_hit [ALARM_SLOTS];
   logic [ALARM_SLOTS-1:0] hit_vec;
   logic [ALARM_SLOTS-1:0] save_vec;
   logic [ALARM_SLOTS-1:0] cell_wr;
   slot_type       wr_slot;
   logic [2:0]     fired_idx;
   logic           any_hit;
   logic           scan_done;
   logic           req_accept;
   logic           rsp_load;
   eng_cmd_type    eng_cmd;
   eng_rsp_type    eng_rsp;
   eng_status_type eng_status;

   logic       rsp_valid_ff;
   logic       rsp_on_ff, rsp_off_ff, rsp_alarm_ff, rsp_find_ff;
   logic       rsp_fired_ff, rsp_save_ff, rsp_ended_ff;
   logic [2:0] rsp_slot_ff;

   // weekday to mask bit; Sunday is bit 0, Monday bit 6 down to Saturday bit 1
   function automatic logic [DAYS_W-1:0] day_bit(input logic [2:0] wd);
      logic [DAYS_W-1:0] m;
      case (wd)
         3'd0:    m = 7'h01;
         3'd1:    m = 7'h40;
         3'd2:    m = 7'h20;
         3'd3:    m = 7'h10;
         3'd4:    m = 7'h08;
         3'd5:    m = 7'h04;
         3'd6:    m = 7'h02;
         default: m = 7'h00;  // no weekday: only one-shot slots can match
      endcase
      return m;
   endfunction

   // Hold off new items during a walk, and while the result register is stalled.
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // Launch the search token into the first cell.
   always_comb begin
      launch_in.valid    = req_accept && (req_action == ACT_CHECK);
      launch_in.hour     = req_now_hour;
      launch_in.minute   = req_now_minute;
      launch_in.day_mask = day_bit(req_now_weekday);
   end

   assign chain[0] = launch_ff;

   always_comb begin
      wr_slot.enable = req_slot_enable;
      wr_slot.hour   = req_slot_hour;
      wr_slot.minute = req_slot_minute;
      wr_slot.days   = req_slot_days;
      for (int i = 0; i < ALARM_SLOTS; i++) begin
         cell_wr[i] = req_accept && (req_action == ACT_WRITE) && (int'(req_slot_index) == i);
      end
   end

   // Row of slot cells; the first enabled match keeps the token, so order is priority.
   for (genvar g = 0; g < ALARM_SLOTS; g++) begin : g_cell
      wam_slot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (cell_wr[g]),
         .wr_slot   (wr_slot),
         .probe_in  (chain[g]),
         .probe_out (chain[g+1]),
         .hit_out   (cell_hit[g])
      );
   end

   always_comb begin
      fired_idx = '0;
      for (int i = 0; i < ALARM_SLOTS; i++) begin
         hit_vec[i]  = cell_hit[i].hit;
         save_vec[i] = cell_hit[i].save;
         if (cell_hit[i].hit) begin
            fired_idx = 3'(i);
         end
      end
      any_hit   = |hit_vec;
      // walk ends on a hit or when the token drops off the last cell
      scan_done = (state_ff == ST_SCAN) && (any_hit || chain[ALARM_SLOTS].valid);
   end

   always_comb begin
      eng_cmd.alarm = (state_ff == ST_SCAN) && any_hit;
      eng_cmd.tick  = req_accept && (req_action == ACT_TICK);
      eng_cmd.stop  = req_accept && (req_action == ACT_STOP);
      eng_cmd.find  = req_accept && (req_action == ACT_FIND);
   end

   wam_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (eng_cmd),
      .rsp    (eng_rsp),
      .status (eng_status)
   );

   // Every item but a minute check resolves in its accept cycle.
   assign rsp_load = (req_accept && (req_action != ACT_CHECK)) || scan_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= launch_in;
         unique case (state_ff)
            ST_IDLE: if (launch_in.valid) state_ff <= ST_SCAN;
            ST_SCAN: if (scan_done)       state_ff <= ST_IDLE;
            default:                      state_ff <= ST_IDLE;
         endcase
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // result payload: no reset needed
      if (rsp_load) begin
         rsp_on_ff    <= eng_rsp.on_pulse;
         rsp_off_ff   <= eng_rsp.off_pulse;
         rsp_alarm_ff <= eng_rsp.alarm_active;
         rsp_find_ff  <= eng_rsp.find_active;
         rsp_ended_ff <= eng_rsp.ended;
         rsp_fired_ff <= scan_done && any_hit;
         rsp_slot_ff  <= scan_done ? fired_idx : '0;
         rsp_save_ff  <= scan_done && (|save_vec);
      end
   end

   // Configuration registers; a write to an unused index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_on_ms   <= MS_W'(1000);
         cfg_ff.alarm_off_ms  <= MS_W'(500);
         cfg_ff.alarm_repeats <= REP_W'(5);
         cfg_ff.find_on_ms    <= MS_W'(1000);
         cfg_ff.find_off_ms   <= MS_W'(500);
         cfg_ff.find_repeats  <= REP_W'(10);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALARM_ON:  cfg_ff.alarm_on_ms   <= csr_wr_data;
            CSR_ALARM_OFF: cfg_ff.alarm_off_ms  <= csr_wr_data;
            CSR_ALARM_REP: cfg_ff.alarm_repeats <= csr_wr_data[REP_W-1:0];
            CSR_FIND_ON:   cfg_ff.find_on_ms    <= csr_wr_data;
            CSR_FIND_OFF:  cfg_ff.find_off_ms   <= csr_wr_data;
            CSR_FIND_REP:  cfg_ff.find_repeats  <= csr_wr_data[REP_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_buzz_on_pulse  = rsp_on_ff;
   assign rsp_buzz_off_pulse = rsp_off_ff;
   assign rsp_alarm_active   = rsp_alarm_ff;
   assign rsp_find_active    = rsp_find_ff;
   assign rsp_alarm_fired    = rsp_fired_ff;
   assign rsp_fired_slot     = rsp_slot_ff;
   assign rsp_save_needed    = rsp_save_ff;
   assign rsp_pattern_ended  = rsp_ended_ff;

   // at most one cell may take the token
   `WAM_ASSERT_NOW(a_single_hit, clock, reset, 1'b1, $onehot0(hit_vec), "two slot cells hit")
   // the two patterns never share the engine
   `WAM_ASSERT_NOW(a_one_pattern, clock, reset, 1'b1,
                   !(eng_status.alarm_running && eng_status.find_running), "both patterns run")
   // a fired alarm always leaves the alarm pattern running
   `WAM_ASSERT_NOW(a_fired_active, clock, reset, rsp_valid_ff && rsp_alarm_fired,
                   rsp_alarm_active, "alarm fired without alarm pattern")
   // a minute check item starts a walk with its token in the first cell
   `WAM_ASSERT_NEXT(a_walk_start, clock, reset, req_accept && (req_action == ACT_CHECK),
                    (state_ff == ST_SCAN) && launch_ff.valid, "minute check did not start walk")

endmodule

`default_nettype wire
